/* src/lobt_pkg.sv */
// Package with the command and status codes, the input beat format and the stored order format.
package lobt_pkg;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_CANCEL = 3'd1,
		CMD_AMEND  = 3'd2,
		CMD_COUNT  = 3'd3,
		CMD_TOPBUY = 3'd4,
		CMD_BSELL  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NONE     = 3'd1,
		ST_NOTIME   = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	localparam int KEY_W  = 32;
	localparam int VOL_W  = 32;
	localparam int PRC_W  = 32;
	localparam int SEC_W  = 17;
	localparam int SEQ_W  = 32;
	localparam int SYM_IN_W = 6;
	localparam int IN_W   = 3 + SYM_IN_W + 1 + KEY_W + VOL_W + PRC_W + SEC_W;
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8;

	// One decoded input beat.
	typedef struct packed {
		logic [SEC_W-1:0]    sec;
		logic [PRC_W-1:0]    price;
		logic [VOL_W-1:0]    vol;
		logic [KEY_W-1:0]    key;
		logic                sd;
		logic [SYM_IN_W-1:0] sym;
		logic [2:0]          cmd;
	} item_t;

	// One stored order, as kept in the entry memory.
	typedef struct packed {
		logic [SEC_W-1:0] sec;
		logic [SEQ_W-1:0] seq;
		logic [PRC_W-1:0] price;
		logic [VOL_W-1:0] vol;
		logic [KEY_W-1:0] key;
	} order_t;

endpackage

/* src/lobt_store.sv */
// Order memory: tags and order data with one write port and one registered read port.
module lobt_store #(
	parameter int ENTRIES = 256,
	parameter int SYM_W   = 6,
	parameter int IDX_W   = 8
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IDX_W-1:0]     waddr,
	input  logic [SYM_W-1:0]     wsym,
	input  logic                 wsd,
	input  lobt_pkg::order_t     word,
	input  logic [IDX_W-1:0]     raddr,
	output logic [SYM_W-1:0]     rsym,
	output logic                 rsd,
	output lobt_pkg::order_t     rord
);
	import lobt_pkg::*;

	logic [SYM_W:0]     tag_mem [ENTRIES];
	order_t             ord_mem [ENTRIES];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			tag_mem[waddr] <= {wsym, wsd};
			ord_mem[waddr] <= word;
		end
		{rsym, rsd} <= tag_mem[raddr];
		rord        <= ord_mem[raddr];
	end

endmodule

/* src/limit_order_book_table.sv */
// Top level of the order table: command sequencer, table scan and result beats.
// Each valid command sweeps the table, one entry per cycle, through a memory with
// a registered read port; a top-buy query makes up to TOP_COUNT sweeps. An insert
// or amend that writes back passes through a write state after its sweep.
// A stalled result output holds the command at the end of its sweep until the output
// register frees. An insert takes the lowest free slot from a valid-bit scan in the same
// sweep. Valid bits sit in flip-flops cleared by reset; the rest of each entry is only
// read once written. Results leave through a register, one beat per cycle while the
// output is ready, and the next command may already be accepted once the last beat of
// the previous one is queued.
module limit_order_book_table #(
	parameter int ENTRIES   = 256,
	parameter int SYMBOLS   = 64,
	parameter int TOP_COUNT = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// tdata: command[2:0], symbol[8:3], side[9], order_key[41:10], volume_in[73:42],
	// price_in[105:74], second_of_day[122:106], zero fill to 128 bits.
	input  logic [lobt_pkg::IN_TW-1:0]    s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tdata: status[2:0], rank[4:3], key_out[36:5], volume_out[68:37],
	// price_out[100:69], time_out[117:101], order_count[126:118], zero fill to 128.
	output logic [127:0]                  m_axis_tdata,
	output logic                          m_axis_tlast
);
	import lobt_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int SYM_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
	localparam int RK_W  = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_DONE  = 5'b00100,
		S_EMIT  = 5'b01000,
		S_WRITE = 5'b10000
	} state_t;

	state_t state_q;
	item_t  it_q;
	logic [SYM_W-1:0]   sym_q;
	logic [ENTRIES-1:0] valid_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [CNT_W:0]     addr_q;
	logic               rd_s1;
	logic [IDX_W-1:0]   ridx_s1;
	logic [RK_W-1:0]    pass_q;
	logic [ENTRIES-1:0] picked_q;
	logic               hit_q;
	logic               any_q;
	logic [IDX_W-1:0]   best_q;
	order_t             bord_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               free_q;
	logic [IDX_W-1:0]   fidx_q;

	// Memory port signals.
	logic               we;
	logic [IDX_W-1:0]   waddr;
	order_t             word;
	logic [SYM_W-1:0]   rsym;
	logic               rsd;
	order_t             rord;

	// Output register.
	logic               ov_q;
	logic [127:0]       od_q;
	logic               ol_q;
	logic               hold_q;

	item_t in_it;
	assign in_it = item_t'(s_axis_tdata[IN_W-1:0]);

	logic [SYM_W-1:0] in_sym;
	assign in_sym = SYM_W'(32'(in_it.sym) % SYMBOLS);

	// A held final top-buy beat must leave before the next command starts.
	assign s_axis_tready = (state_q == S_IDLE) && !hold_q;

	logic in_fire;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	lobt_store #(.ENTRIES(ENTRIES), .SYM_W(SYM_W), .IDX_W(IDX_W)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wsym(sym_q), .wsd(it_q.sd), .word(word),
		.raddr(addr_q[IDX_W-1:0]), .rsym(rsym), .rsd(rsd), .rord(rord)
	);

	// Candidate qualification for the entry read last cycle.
	logic   c_val, c_sym, c_take;
	logic   c_earlier;
	always_comb begin
		c_val = valid_q[ridx_s1] && rd_s1;
		c_sym = c_val && (rsym == sym_q);
		c_earlier = (rord.seq < bord_q.seq) ||
			((rord.seq == bord_q.seq) && (ridx_s1 < best_q));
		c_take = 1'b0;
		case (it_q.cmd)
			CMD_CANCEL, CMD_AMEND:
				c_take = c_sym && (rsd == it_q.sd) && (rord.key == it_q.key) &&
					(!hit_q || c_earlier);
			CMD_TOPBUY:
				c_take = c_sym && !rsd && !picked_q[ridx_s1] && (!hit_q ||
					(rord.vol > bord_q.vol) || ((rord.vol == bord_q.vol) && c_earlier));
			CMD_BSELL:
				c_take = c_sym && rsd && (rord.sec == it_q.sec) && (rord.price != '0) &&
					(!hit_q || (rord.price > bord_q.price) ||
					((rord.price == bord_q.price) && c_earlier));
			default: c_take = 1'b0;
		endcase
	end

	// Write port: insert writes the whole entry, amend rewrites the amounts.
	always_comb begin
		we    = 1'b0;
		waddr = best_q;
		word  = bord_q;
		if (state_q == S_WRITE) begin
			we = 1'b1;
			if (it_q.cmd == CMD_INSERT) begin
				waddr = fidx_q;
				word  = '{sec: it_q.sec, seq: seq_q, price: it_q.price,
					vol: it_q.vol, key: it_q.key};
			end else begin
				word.vol   = it_q.vol;
				word.price = it_q.price;
			end
		end
	end

	// Result beat built from the current command outcome.
	logic [2:0]   r_st;
	logic         r_rep;
	logic         r_last;
	order_t       r_ord;
	always_comb begin
		r_st   = ST_OK;
		r_rep  = 1'b0;
		r_last = 1'b1;
		r_ord  = bord_q;
		case (it_q.cmd)
			CMD_INSERT: begin
				r_st  = free_q ? ST_OK : ST_FULL;
				r_rep = free_q;
				r_ord = '{sec: it_q.sec, seq: seq_q, price: it_q.price,
					vol: it_q.vol, key: it_q.key};
			end
			CMD_CANCEL: begin
				r_st = hit_q ? ST_OK : ST_NOTFOUND;
				r_rep = hit_q;
			end
			CMD_AMEND: begin
				r_st = hit_q ? ST_OK : ST_NOTFOUND;
				r_rep = hit_q;
				r_ord.vol = it_q.vol;
				r_ord.price = it_q.price;
			end
			CMD_TOPBUY: begin
				r_st  = (hit_q || pass_q != '0) ? ST_OK : ST_NONE;
				r_rep = hit_q;
				r_last = !hit_q || (32'(pass_q) == TOP_COUNT - 1);
			end
			CMD_BSELL: begin
				r_st  = hit_q ? ST_OK : (any_q ? ST_NOTIME : ST_NONE);
				r_rep = hit_q;
			end
			default: r_st = ST_OK;
		endcase
	end

	logic         do_beat;
	assign do_beat = (state_q == S_DONE) && !(ov_q && !m_axis_tready) &&
		!((it_q.cmd == CMD_TOPBUY) && !hit_q && (pass_q != '0));

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			seq_q    <= '0;
			addr_q   <= '0;
			rd_s1    <= 1'b0;
			pass_q   <= '0;
			picked_q <= '0;
			hit_q    <= 1'b0;
			any_q    <= 1'b0;
			free_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_it.cmd <= CMD_BSELL) begin
							state_q  <= S_SCAN;
						end
						addr_q   <= '0;
						rd_s1    <= 1'b0;
						pass_q   <= '0;
						picked_q <= '0;
						hit_q    <= 1'b0;
						any_q    <= 1'b0;
						free_q   <= 1'b0;
						cnt_q    <= '0;
					end
				end
				S_SCAN: begin
					rd_s1   <= (addr_q < (CNT_W+1)'(ENTRIES));
					if (addr_q < (CNT_W+1)'(ENTRIES)) begin
						addr_q <= addr_q + 1'b1;
					end
					if (rd_s1) begin
						if (c_take) begin
							hit_q <= 1'b1;
							best_q <= ridx_s1;
							bord_q <= rord;
						end
						if (c_sym) cnt_q <= cnt_q + 1'b1;
						if (c_sym && rsd) any_q <= 1'b1;
						if (!valid_q[ridx_s1] && !free_q) begin
							free_q <= 1'b1;
							fidx_q <= ridx_s1;
						end
					end
					if (!rd_s1 && addr_q == (CNT_W+1)'(ENTRIES)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (do_beat) begin
						if (it_q.cmd == CMD_TOPBUY && !r_last) begin
							picked_q[best_q] <= 1'b1;
							pass_q <= pass_q + 1'b1;
							hit_q  <= 1'b0;
							addr_q <= '0;
							rd_s1  <= 1'b0;
							state_q <= S_SCAN;
						end else if ((it_q.cmd == CMD_INSERT && free_q) ||
								(it_q.cmd == CMD_AMEND && hit_q)) begin
							state_q <= S_WRITE;
						end else begin
							if (it_q.cmd == CMD_CANCEL && hit_q) valid_q[best_q] <= 1'b0;
							state_q <= S_IDLE;
						end
					end else if ((it_q.cmd == CMD_TOPBUY) && !hit_q && (pass_q != '0)) begin
						// Fewer buy orders than ranks: the previous beat was final.
						state_q <= S_IDLE;
					end
				end
				S_WRITE: begin
					if (it_q.cmd == CMD_INSERT) begin
						valid_q[fidx_q] <= 1'b1;
						seq_q <= seq_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command capture and read pipeline index.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			it_q  <= in_it;
			sym_q <= in_sym;
		end
		ridx_s1 <= addr_q[IDX_W-1:0];
	end

	// A top-buy beat that is not final is retroactively marked last when the next
	// pass finds nothing; a beat that may be followed is held until its successor is known.
	logic [127:0]     hd_q;
	logic [127:0]     new_d;
	logic [RK_W-1:0]  rk;
	assign rk = (it_q.cmd == CMD_TOPBUY) ? pass_q : '0;
	assign new_d = {1'b0, 9'(r_rep ? 9'd0 : ((it_q.cmd == CMD_COUNT) ? 9'(cnt_q) : 9'd0)),
		r_rep ? r_ord.sec : 17'd0, r_rep ? r_ord.price : 32'd0,
		r_rep ? r_ord.vol : 32'd0, r_rep ? r_ord.key : 32'd0, 2'(rk), r_st};

	logic late_end;
	assign late_end = (state_q == S_DONE) && (it_q.cmd == CMD_TOPBUY) && !hit_q &&
		(pass_q != '0);

	// Output register with one holding slot for an unfinished top-buy beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			ol_q   <= 1'b0;
			hold_q <= 1'b0;
		end else begin
			if (ov_q && m_axis_tready) ov_q <= 1'b0;
			if (late_end && hold_q && !(ov_q && !m_axis_tready)) begin
				ov_q   <= 1'b1;
				od_q   <= hd_q;
				ol_q   <= 1'b1;
				hold_q <= 1'b0;
			end else if (do_beat) begin
				if (hold_q) begin
					ov_q   <= 1'b1;
					od_q   <= hd_q;
					ol_q   <= 1'b0;
					hold_q <= 1'b0;
				end
				if (it_q.cmd == CMD_TOPBUY && !r_last) begin
					hold_q <= 1'b1;
					hd_q   <= new_d;
				end else if (!hold_q) begin
					ov_q <= 1'b1;
					od_q <= new_d;
					ol_q <= 1'b1;
				end else begin
					hold_q <= 1'b1;
					hd_q   <= new_d;
				end
			end else if (state_q == S_IDLE && hold_q && !(ov_q && !m_axis_tready)) begin
				ov_q   <= 1'b1;
				od_q   <= hd_q;
				ol_q   <= 1'b1;
				hold_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = od_q;
	assign m_axis_tlast  = ol_q;

	// A new beat never overwrites an untaken one.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !m_axis_tready |=> ov_q && $stable(od_q))
		else $error("result beat overwritten");
	// The free-slot index always points at a slot that was free.
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE && it_q.cmd == CMD_INSERT |-> !valid_q[fidx_q])
		else $error("insert into a live slot");
	// Cancel clears exactly one live entry.
	a_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && do_beat && it_q.cmd == CMD_CANCEL && hit_q
		|=> $countones(valid_q) == $countones($past(valid_q)) - 1)
		else $error("cancel did not remove one entry");

endmodule
